FILE: rtl/mjs_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and the job ordering function of the multicore job scheduler.
// Used by mjs_queue and multicore_job_scheduler_unit; depends on nothing else.
package mjs_pkg;

  localparam int MAX_CORES_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF = 64;
  // Core scan counters cover the values 0 to 63.
  localparam int CORE_CNT_W      = 6;

  localparam logic [2:0] SCH_FCFS = 3'd0;
  localparam logic [2:0] SCH_SJF  = 3'd1;
  localparam logic [2:0] SCH_PSJF = 3'd2;
  localparam logic [2:0] SCH_PRI  = 3'd3;
  localparam logic [2:0] SCH_PPRI = 3'd4;
  localparam logic [2:0] SCH_RR   = 3'd5;

  localparam logic [1:0] REQ_NEW = 2'd0;
  localparam logic [1:0] REQ_FIN = 2'd1;
  localparam logic [1:0] REQ_EXP = 2'd2;
  localparam logic [1:0] REQ_NOP = 2'd3;

  localparam logic [1:0] CFG_SCHEME = 2'd0;
  localparam logic [1:0] CFG_CORES  = 2'd1;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] arr;
    logic [15:0] run;
    logic [15:0] rem;
    logic [15:0] pri;
  } job_t;

  typedef struct packed {
    job_t        job;
    logic [31:0] last;
  } core_ent_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] job_id;
    logic [31:0] now;
    logic [15:0] run_length;
    logic [15:0] job_priority;
    logic [2:0]  core_sel;
  } sched_in_t;

  typedef struct packed {
    logic        dispatched;
    logic [2:0]  core_out;
    logic [15:0] job_out;
    logic        fault;
  } sched_out_t;

  typedef struct packed {
    logic peek;
    logic pop;
    logic ins;
  } q_cmd_t;

  typedef struct packed {
    logic done;
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ADV_RD, ST_ADV_WR, ST_ADV_CMP, ST_DECIDE, ST_PRE_DAT,
    ST_FIN_DAT, ST_EXP_DAT, ST_HEAD_WAIT, ST_FIN_GO, ST_EXP_GO, ST_INS_WAIT,
    ST_DONE
  } sched_st_t;

  typedef enum logic [2:0] {
    Q_IDLE, Q_PEEK, Q_SCAN_RD, Q_SCAN_DAT, Q_SHIFT_RD, Q_SHIFT_WR
  } q_st_t;

  // Signed ordering of a against b: scheme key, arrival on a tie; zero for RR.
  function automatic logic signed [33:0] key_cmp(input logic [2:0] sch,
                                                 input job_t a, input job_t b);
    logic signed [33:0] da;
    logic signed [33:0] d;
    da = $signed({2'b00, a.arr}) - $signed({2'b00, b.arr});
    d  = '0;
    case (sch)
      SCH_FCFS: return da;
      SCH_SJF:  d = $signed({18'd0, a.run}) - $signed({18'd0, b.run});
      SCH_PSJF: d = $signed({18'd0, a.rem}) - $signed({18'd0, b.rem});
      SCH_PRI, SCH_PPRI: d = $signed({18'd0, a.pri}) - $signed({18'd0, b.pri});
      default:  return '0;
    endcase
    return (d != '0) ? d : da;
  endfunction

endpackage

FILE: rtl/mjs_queue.sv
`timescale 1ns / 1ps
// Sorted ready queue of the job scheduler, held as a ring in one synchronous memory.
// Depends on mjs_pkg for the job record, command and status types and key_cmp.
module mjs_queue #(
  parameter int QUEUE_DEPTH = mjs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [2:0]      scheme,
  input  mjs_pkg::q_cmd_t cmd,
  input  mjs_pkg::job_t   ins_rec,
  output mjs_pkg::q_stat_t stat,
  output mjs_pkg::job_t   head_rec
);
  import mjs_pkg::*;

  localparam int QAW  = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW   = CNTW + 1;

  job_t q_mem [QUEUE_DEPTH];

  q_st_t           st_r, st_nxt;
  logic [QAW-1:0]  head_r, head_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic [CNTW-1:0] idx_r, idx_nxt;
  logic [CNTW-1:0] k_r, k_nxt;
  job_t            ins_r, ins_nxt;
  job_t            rdata_r;

  logic            re, we;
  logic [QAW-1:0]  raddr, waddr;
  job_t            wdata;
  logic            done;

  // Logical position i from the head, wrapped onto the ring.
  function automatic logic [QAW-1:0] phys(input logic [QAW-1:0] h, input logic [CNTW-1:0] i);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(i);
    if (s >= SW'(QUEUE_DEPTH)) s = s - SW'(QUEUE_DEPTH);
    return s[QAW-1:0];
  endfunction

  always_comb begin
    st_nxt    = st_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    k_nxt     = k_r;
    ins_nxt   = ins_r;
    re        = 1'b0;
    raddr     = '0;
    we        = 1'b0;
    waddr     = '0;
    wdata     = ins_r;
    done      = 1'b0;
    case (st_r)
      Q_IDLE: begin
        if (cmd.pop) begin
          head_nxt  = phys(head_r, CNTW'(1));
          count_nxt = count_r - CNTW'(1);
        end
        if (cmd.peek) begin
          re     = 1'b1;
          raddr  = head_r;
          st_nxt = Q_PEEK;
        end else if (cmd.ins) begin
          ins_nxt = ins_rec;
          idx_nxt = '0;
          st_nxt  = Q_SCAN_RD;
        end
      end
      Q_PEEK: begin
        done   = 1'b1;
        st_nxt = Q_IDLE;
      end
      Q_SCAN_RD: begin
        if (idx_r == count_r) begin
          k_nxt  = count_r;
          st_nxt = Q_SHIFT_RD;
        end else begin
          re     = 1'b1;
          raddr  = phys(head_r, idx_r);
          st_nxt = Q_SCAN_DAT;
        end
      end
      Q_SCAN_DAT: begin
        // The new job goes in front of the first entry it sorts below.
        if (key_cmp(scheme, ins_r, rdata_r) < 0) begin
          k_nxt  = count_r;
          st_nxt = Q_SHIFT_RD;
        end else begin
          idx_nxt = idx_r + CNTW'(1);
          st_nxt  = Q_SCAN_RD;
        end
      end
      Q_SHIFT_RD: begin
        if (k_r == idx_r) begin
          we        = 1'b1;
          waddr     = phys(head_r, idx_r);
          wdata     = ins_r;
          count_nxt = count_r + CNTW'(1);
          done      = 1'b1;
          st_nxt    = Q_IDLE;
        end else begin
          re     = 1'b1;
          raddr  = phys(head_r, k_r - CNTW'(1));
          st_nxt = Q_SHIFT_WR;
        end
      end
      Q_SHIFT_WR: begin
        we     = 1'b1;
        waddr  = phys(head_r, k_r);
        wdata  = rdata_r;
        k_nxt  = k_r - CNTW'(1);
        st_nxt = Q_SHIFT_RD;
      end
      default: st_nxt = Q_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= Q_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      st_r    <= st_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    k_r   <= k_nxt;
    ins_r <= ins_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) q_mem[waddr] <= wdata;
    if (re) rdata_r <= q_mem[raddr];
  end

  assign stat.done  = done;
  assign stat.full  = (count_r == CNTW'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign head_rec   = rdata_r;

endmodule

FILE: rtl/multicore_job_scheduler_unit.sv
`timescale 1ns / 1ps
// Top level of the multicore job scheduler: event sequencer, core table memory and queue.
// Depends on mjs_pkg and mjs_queue.
//
// Usage: scheduling events arrive as words on the in_ channel (new job, job finished,
// quantum expired) and each event yields exactly one result word on the out_ channel.
// The cfg_ channel sets the scheme and the number of cores; write it only while idle.
// One event at a time is in work; in_ready is high only between events.
// The remaining-time update reads, writes and compares each busy active core and
// skips each idle one; table accesses follow, and a queue insertion compares entries
// and then moves those behind the new job.
// The single read port of the core table and of the queue memory paces these steps.
// Reset clears the busy flags, the queue fill count and the state and configuration
// registers (scheme 0, one core). The memories need no clearing pass.
// A finished result sits in an output register; the next event is accepted while it
// waits, and the block holds its next result until out_ready takes the first.
module multicore_job_scheduler_unit #(
  parameter int MAX_CORES   = mjs_pkg::MAX_CORES_DEF,
  parameter int QUEUE_DEPTH = mjs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mjs_pkg::sched_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mjs_pkg::sched_out_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [3:0]           cfg_data
);
  import mjs_pkg::*;

  localparam int CIW = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;

  core_ent_t core_mem [MAX_CORES];

  sched_st_t              state_r, state_nxt;
  sched_in_t              in_r, in_nxt;
  logic [2:0]             scheme_r;
  logic [3:0]             cores_r;
  logic [MAX_CORES-1:0]   busy_r, busy_nxt;
  logic [CORE_CNT_W-1:0]  scan_r, scan_nxt;
  logic                   best_vld_r, best_vld_nxt;
  logic [CIW-1:0]         best_idx_r, best_idx_nxt;
  logic signed [33:0]     best_c_r, best_c_nxt;
  logic [31:0]            best_arr_r, best_arr_nxt;
  job_t                   upd_r, upd_nxt;
  job_t                   hold_r, hold_nxt;
  sched_out_t             res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;
  sched_out_t             out_data_r, out_data_nxt;

  logic                   cre, cwe;
  logic [CIW-1:0]         craddr, cwaddr;
  core_ent_t              cwdata;
  core_ent_t              cr_data_r;

  q_cmd_t                 q_cmd;
  job_t                   q_rec;
  q_stat_t                q_stat;
  job_t                   q_head;

  logic [CORE_CNT_W-1:0]  n_act;
  logic [CORE_CNT_W-1:0]  c_ext;
  logic [CIW-1:0]         cidx;
  logic [CIW-1:0]         sidx;
  logic                   c_ok;
  logic                   free_vld;
  logic [CIW-1:0]         free_idx;
  logic                   preempt_ok;
  job_t                   nj;

  mjs_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .scheme   (scheme_r),
    .cmd      (q_cmd),
    .ins_rec  (q_rec),
    .stat     (q_stat),
    .head_rec (q_head)
  );

  assign n_act = ({2'b00, cores_r} > CORE_CNT_W'(MAX_CORES)) ? CORE_CNT_W'(MAX_CORES)
                                                             : {2'b00, cores_r};
  assign c_ext = {3'b000, in_r.core_sel};
  assign cidx  = c_ext[CIW-1:0];
  assign sidx  = scan_r[CIW-1:0];
  assign c_ok  = (c_ext < n_act) && busy_r[cidx];
  assign preempt_ok = best_vld_r && (scheme_r == SCH_PSJF || scheme_r == SCH_PPRI);

  assign nj.id  = in_r.job_id;
  assign nj.arr = in_r.now;
  assign nj.run = in_r.run_length;
  assign nj.rem = in_r.run_length;
  assign nj.pri = in_r.job_priority;

  // Lowest idle core among the active ones.
  always_comb begin
    free_vld = 1'b0;
    free_idx = '0;
    for (int i = 0; i < MAX_CORES; i++) begin
      if (!free_vld && (CORE_CNT_W'(i) < n_act) && !busy_r[i]) begin
        free_vld = 1'b1;
        free_idx = CIW'(i);
      end
    end
  end

  always_comb begin
    core_ent_t          ent;
    logic [31:0]        el;
    logic [15:0]        rem_new;
    logic signed [33:0] v;
    state_nxt     = state_r;
    in_nxt        = in_r;
    busy_nxt      = busy_r;
    scan_nxt      = scan_r;
    best_vld_nxt  = best_vld_r;
    best_idx_nxt  = best_idx_r;
    best_c_nxt    = best_c_r;
    best_arr_nxt  = best_arr_r;
    upd_nxt       = upd_r;
    hold_nxt      = hold_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    cre           = 1'b0;
    craddr        = '0;
    cwe           = 1'b0;
    cwaddr        = '0;
    cwdata        = '{job: nj, last: in_r.now};
    q_cmd         = '0;
    q_rec         = nj;
    ent           = cr_data_r;
    el            = (in_r.now >= ent.last) ? (in_r.now - ent.last) : 32'd0;
    rem_new       = ({16'd0, ent.job.rem} > el) ? (ent.job.rem - el[15:0]) : 16'd0;
    v             = key_cmp(scheme_r, nj, upd_r);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          in_nxt       = in_data;
          res_nxt      = '0;
          scan_nxt     = '0;
          best_vld_nxt = 1'b0;
          best_c_nxt   = '0;
          state_nxt    = (in_data.req_type == REQ_NOP) ? ST_DONE : ST_ADV_RD;
        end
      end
      ST_ADV_RD: begin
        if (scan_r >= n_act) begin
          state_nxt = ST_DECIDE;
        end else if (busy_r[sidx]) begin
          cre       = 1'b1;
          craddr    = sidx;
          state_nxt = ST_ADV_WR;
        end else begin
          scan_nxt = scan_r + CORE_CNT_W'(1);
        end
      end
      ST_ADV_WR: begin
        cwe             = 1'b1;
        cwaddr          = sidx;
        cwdata          = ent;
        cwdata.job.rem  = rem_new;
        cwdata.last     = in_r.now;
        upd_nxt         = ent.job;
        upd_nxt.rem     = rem_new;
        state_nxt       = ST_ADV_CMP;
      end
      ST_ADV_CMP: begin
        // Worst running job for preemption; ties go to the later arrival.
        if (v < best_c_r) begin
          best_vld_nxt = 1'b1;
          best_idx_nxt = sidx;
          best_c_nxt   = v;
          best_arr_nxt = upd_r.arr;
        end else if (v == best_c_r && best_vld_r && best_arr_r < upd_r.arr) begin
          best_idx_nxt = sidx;
          best_arr_nxt = upd_r.arr;
        end
        scan_nxt  = scan_r + CORE_CNT_W'(1);
        state_nxt = ST_ADV_RD;
      end
      ST_DECIDE: begin
        case (in_r.req_type)
          REQ_NEW: begin
            if (free_vld) begin
              cwe                = 1'b1;
              cwaddr             = free_idx;
              busy_nxt[free_idx] = 1'b1;
              res_nxt.dispatched = 1'b1;
              res_nxt.core_out   = 3'(free_idx);
              state_nxt          = ST_DONE;
            end else if (q_stat.full) begin
              res_nxt.fault = 1'b1;
              state_nxt     = ST_DONE;
            end else if (preempt_ok) begin
              cre       = 1'b1;
              craddr    = best_idx_r;
              state_nxt = ST_PRE_DAT;
            end else begin
              q_cmd.ins = 1'b1;
              state_nxt = ST_INS_WAIT;
            end
          end
          REQ_FIN, REQ_EXP: begin
            if (!c_ok) begin
              res_nxt.fault = 1'b1;
              state_nxt     = ST_DONE;
            end else begin
              cre       = 1'b1;
              craddr    = cidx;
              state_nxt = (in_r.req_type == REQ_FIN) ? ST_FIN_DAT : ST_EXP_DAT;
            end
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_PRE_DAT: begin
        q_cmd.ins          = 1'b1;
        q_rec              = cr_data_r.job;
        cwe                = 1'b1;
        cwaddr             = best_idx_r;
        res_nxt.dispatched = 1'b1;
        res_nxt.core_out   = 3'(best_idx_r);
        state_nxt          = ST_INS_WAIT;
      end
      ST_FIN_DAT: begin
        if (cr_data_r.job.id != in_r.job_id) begin
          res_nxt.fault = 1'b1;
          state_nxt     = ST_DONE;
        end else begin
          busy_nxt[cidx] = 1'b0;
          if (!q_stat.empty) begin
            q_cmd.peek = 1'b1;
            state_nxt  = ST_HEAD_WAIT;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_EXP_DAT: begin
        hold_nxt = cr_data_r.job;
        if (q_stat.empty) begin
          res_nxt.dispatched = 1'b1;
          res_nxt.core_out   = in_r.core_sel;
          res_nxt.job_out    = cr_data_r.job.id;
          state_nxt          = ST_DONE;
        end else begin
          q_cmd.peek = 1'b1;
          state_nxt  = ST_HEAD_WAIT;
        end
      end
      ST_HEAD_WAIT: begin
        if (q_stat.done) begin
          state_nxt = (in_r.req_type == REQ_FIN) ? ST_FIN_GO : ST_EXP_GO;
        end
      end
      ST_FIN_GO: begin
        q_cmd.pop          = 1'b1;
        cwe                = 1'b1;
        cwaddr             = cidx;
        cwdata.job         = q_head;
        busy_nxt[cidx]     = 1'b1;
        res_nxt.dispatched = 1'b1;
        res_nxt.core_out   = in_r.core_sel;
        res_nxt.job_out    = q_head.id;
        state_nxt          = ST_DONE;
      end
      ST_EXP_GO: begin
        res_nxt.dispatched = 1'b1;
        res_nxt.core_out   = in_r.core_sel;
        // The running job keeps its core when it sorts ahead of the queue head.
        if (key_cmp(scheme_r, hold_r, q_head) < 0) begin
          res_nxt.job_out = hold_r.id;
          state_nxt       = ST_DONE;
        end else begin
          q_cmd.pop       = 1'b1;
          q_cmd.ins       = 1'b1;
          q_rec           = hold_r;
          cwe             = 1'b1;
          cwaddr          = cidx;
          cwdata.job      = q_head;
          res_nxt.job_out = q_head.id;
          state_nxt       = ST_INS_WAIT;
        end
      end
      ST_INS_WAIT: begin
        if (q_stat.done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      busy_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r       <= in_nxt;
    scan_r     <= scan_nxt;
    best_vld_r <= best_vld_nxt;
    best_idx_r <= best_idx_nxt;
    best_c_r   <= best_c_nxt;
    best_arr_r <= best_arr_nxt;
    upd_r      <= upd_nxt;
    hold_r     <= hold_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scheme_r <= SCH_FCFS;
      cores_r  <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SCHEME: scheme_r <= cfg_data[2:0];
        CFG_CORES:  cores_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cwe) core_mem[cwaddr] <= cwdata;
    if (cre) cr_data_r <= core_mem[craddr];
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  a_disp_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.dispatched |-> !out_data.fault)
    else $error("result both dispatched and faulted");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while an event is in work");

  a_idle_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.dispatched |-> out_data.job_out == '0 && out_data.core_out == '0)
    else $error("undispatched result carries a core or job");

  a_queue_wait_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE |-> !q_stat.done)
    else $error("queue finished an operation the sequencer did not wait for");

endmodule
